@@ rtl/core/clebuf_pkg.sv @@
// ----------------------------------------------------------------------------
// clebuf_pkg
// Shared types and command codes for the cursor line edit buffer.
// ----------------------------------------------------------------------------
package clebuf_pkg;

	localparam int FUNC_W = 3;
	localparam int CHAR_W = 8;

	typedef logic [FUNC_W-1:0] func_t;
	typedef logic [CHAR_W-1:0] char_t;

	localparam func_t CMD_APPEND = 3'd0;
	localparam func_t CMD_HOME   = 3'd1;
	localparam func_t CMD_END    = 3'd2;
	localparam func_t CMD_LEFT   = 3'd3;
	localparam func_t CMD_RIGHT  = 3'd4;
	localparam func_t CMD_FLUSH  = 3'd5;

endpackage

@@ rtl/core/cursor_line_edit_buffer.sv @@
// ----------------------------------------------------------------------------
// cursor_line_edit_buffer
// Keystroke line buffer with an insertion cursor, kept as a gap buffer.
// ----------------------------------------------------------------------------
// Usage: drive func and key_char with start high; the command is taken at a
// clock edge where start is high and busy is low. Flush results come out on
// out_char and last, one per cycle while strobe is high; the receiver must
// take them as they come, it cannot stall the block.
// The text lives in one synchronous memory of CAPACITY bytes: the part before
// the cursor at the bottom, the part after it at the top, the gap in between.
// What each command does:
//   append                 one write at the cursor
//   left, right            one byte read and written across the gap,
//                          no move when the cursor already sits at the edge
//   home, end              bytes moved across the gap one at a time to the edge
//   flush of n bytes       each byte read out in text order, then buffer emptied
//   undefined, empty flush no action
// The memory port does one read and one write per cycle, with read data
// registered. Reset empties the buffer and puts the cursor at
// zero; memory contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module cursor_line_edit_buffer #(
	parameter int CAPACITY = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  clebuf_pkg::func_t    func,
	input  clebuf_pkg::char_t    key_char,
	output logic                 strobe,
	output clebuf_pkg::char_t    out_char,
	output logic                 last
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MV_RD = 3'd1;
	localparam logic [2:0] ST_MV_WR = 3'd2;
	localparam logic [2:0] ST_FL_RD = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;

	logic [2:0]            state_q;
	logic [CW-1:0]         pre_q;
	logic [CW-1:0]         post_q;
	logic [CW-1:0]         idx_q;
	logic                  left_q;
	logic                  rep_q;
	logic                  strobe_s1;
	logic                  last_s1;

	clebuf_pkg::char_t     mem [CAPACITY];
	clebuf_pkg::char_t     mem_rd_q;

	logic                  accept;
	logic [CW-1:0]         len;
	logic [CW-1:0]         gap_lo;
	logic [CW-1:0]         gap_hi;
	logic                  can_move;
	logic                  mem_we;
	logic [CW-1:0]         mem_waddr;
	logic [CW-1:0]         mem_raddr;
	clebuf_pkg::char_t     mem_wdata;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign len      = pre_q + post_q;
	assign gap_hi   = CAP_C - post_q;
	assign gap_lo   = CAP_C - len;
	assign can_move = left_q ? (pre_q != '0) : (post_q != '0);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pre_q;
		mem_wdata = key_char;
		mem_raddr = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && func == clebuf_pkg::CMD_APPEND && len < CAP_C) begin
					mem_we = 1'b1;
				end
			end
			ST_MV_RD: begin
				mem_raddr = left_q ? (pre_q - CW'(1)) : gap_hi;
			end
			ST_MV_WR: begin
				mem_we    = 1'b1;
				mem_waddr = left_q ? (gap_hi - CW'(1)) : pre_q;
				mem_wdata = mem_rd_q;
			end
			ST_FL_RD: begin
				// map the text position across the gap
				mem_raddr = (idx_q < pre_q) ? idx_q : (idx_q + gap_lo);
			end
			ST_DRAIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr[AW-1:0]] <= mem_wdata;
		end
		mem_rd_q <= mem[mem_raddr[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pre_q     <= '0;
			post_q    <= '0;
			idx_q     <= '0;
			left_q    <= 1'b0;
			rep_q     <= 1'b0;
			strobe_s1 <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			strobe_s1 <= 1'b0;
			last_s1   <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (func) inside
							clebuf_pkg::CMD_APPEND: begin
								if (len < CAP_C) begin
									pre_q <= pre_q + CW'(1);
								end
							end
							clebuf_pkg::CMD_HOME, clebuf_pkg::CMD_LEFT: begin
								left_q  <= 1'b1;
								rep_q   <= (func == clebuf_pkg::CMD_HOME);
								state_q <= ST_MV_RD;
							end
							clebuf_pkg::CMD_END, clebuf_pkg::CMD_RIGHT: begin
								left_q  <= 1'b0;
								rep_q   <= (func == clebuf_pkg::CMD_END);
								state_q <= ST_MV_RD;
							end
							clebuf_pkg::CMD_FLUSH: begin
								idx_q <= '0;
								if (len != '0) begin
									state_q <= ST_FL_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_MV_RD: begin
					// stop when the cursor has reached the edge
					state_q <= can_move ? ST_MV_WR : ST_IDLE;
				end
				ST_MV_WR: begin
					if (left_q) begin
						pre_q  <= pre_q - CW'(1);
						post_q <= post_q + CW'(1);
					end else begin
						pre_q  <= pre_q + CW'(1);
						post_q <= post_q - CW'(1);
					end
					state_q <= rep_q ? ST_MV_RD : ST_IDLE;
				end
				ST_FL_RD: begin
					strobe_s1 <= 1'b1;
					idx_q     <= idx_q + CW'(1);
					if (idx_q == len - CW'(1)) begin
						last_s1 <= 1'b1;
						pre_q   <= '0;
						post_q  <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe   = strobe_s1;
	assign last     = last_s1;
	assign out_char = mem_rd_q;

endmodule
